// File: rtl/assert_macros.svh
// Assertion macros shared by the hall angle estimator RTL.
// Simulation gets concurrent assertions; synthesis sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define HAE_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define HAE_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HAE_ASSERT(label, clk, rst, prop, msg)
`define HAE_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// File: rtl/hae_pkg.sv
// Types and constants of the hall angle estimator.
// No dependencies; used by hae_ctrl, hae_datapath and the top level.
package hae_pkg;

  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 48;
  localparam int PERIOD_W    = 32;
  localparam int HALL_W      = 3;
  localparam int OUT_ANGLE_W = 16;
  localparam int STEP_NUM_W  = 24;
  localparam int SPEED_W     = 26;
  localparam int PHASE_W     = 16;
  localparam int STEP_W      = 15;
  localparam int NUM_W       = 26;
  localparam int CNT_W       = $clog2(NUM_W);
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 26;
  localparam int SECTOR_W    = 3;

  localparam logic [STEP_NUM_W-1:0] STEP_NUM_RESET  = 24'd10922667;
  localparam logic [SPEED_W-1:0]    SPEED_NUM_RESET = 26'd50000000;
  localparam logic [PHASE_W-1:0]    PHASE_RESET     = 16'd40050;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_NUM  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_NUM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE     = 2'd2;

  localparam logic [SECTOR_W-1:0] SECTOR_NONE = 3'd6;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_BAD_HALL    = 2'd1,
    STATUS_ZERO_PERIOD = 2'd2
  } hae_status_t;

  typedef struct packed {
    logic load_in;
    logic div_start;
    logic div_step;
    logic commit;
  } hae_cmd_t;

  typedef struct packed {
    logic in_tick;
    logic in_zero_period;
    logic out_free;
  } hae_stat_t;

  function automatic logic [SECTOR_W-1:0] hae_sector(input logic [HALL_W-1:0] code);
    logic [SECTOR_W-1:0] s;
    unique case (code)
      3'd5:    s = 3'd0;
      3'd4:    s = 3'd1;
      3'd6:    s = 3'd2;
      3'd2:    s = 3'd3;
      3'd3:    s = 3'd4;
      3'd1:    s = 3'd5;
      default: s = SECTOR_NONE;
    endcase
    return s;
  endfunction

endpackage

// File: rtl/hae_ctrl.sv
// Controller of the hall angle estimator: input handshake, divider
// sequencing and result hand-off. Depends on hae_pkg and assert_macros.svh.
`include "assert_macros.svh"
module hae_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  hae_pkg::hae_stat_t stat,
  output hae_pkg::hae_cmd_t  cmd
);
  import hae_pkg::*;

  typedef enum logic [1:0] {IDLE, DIV, EMIT} state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;
  logic             ready_q;
  logic             accept;

  assign in_tready = ready_q;
  assign accept    = in_tvalid && ready_q;

  always_comb begin
    cmd.load_in   = accept;
    cmd.div_start = accept && !stat.in_tick && !stat.in_zero_period;
    cmd.div_step  = (state == DIV);
    cmd.commit    = (state == EMIT) && stat.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= IDLE;
      cnt     <= '0;
      ready_q <= 1'b1;
    end else begin
      unique case (state)
        IDLE: begin
          if (accept) begin
            ready_q <= 1'b0;
            if (stat.in_tick || stat.in_zero_period) begin
              state <= EMIT;
            end else begin
              state <= DIV;
              cnt   <= CNT_W'(NUM_W - 1);
            end
          end
        end
        DIV: begin
          if (cnt == '0) begin
            state <= EMIT;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        EMIT: begin
          if (stat.out_free) begin
            state   <= IDLE;
            ready_q <= 1'b1;
          end
        end
        default: begin
          state   <= IDLE;
          ready_q <= 1'b1;
        end
      endcase
    end
  end

  `HAE_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> (state == IDLE && ready_q), "not idle after reset")
  `HAE_ASSERT(a_div_done, clk, rst, (state == DIV && cnt == '0) |=> (state == EMIT), "divide overrun")
  `HAE_ASSERT(a_commit_idle, clk, rst, cmd.commit |=> (state == IDLE && in_tready), "no return to idle")

endmodule

// File: rtl/hae_datapath.sv
// Datapath of the hall angle estimator: config registers, angle state,
// shared restoring divider and output register. Depends on hae_pkg and assert_macros.svh.
`include "assert_macros.svh"
module hae_datapath #(
  parameter int ANGLE_BITS  = 16,
  parameter int PERIOD_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [hae_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hae_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic [hae_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                             in_tuser,
  input  hae_pkg::hae_cmd_t                cmd,
  output hae_pkg::hae_stat_t               stat,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [hae_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic [1:0]                       out_tuser
);
  import hae_pkg::*;

  localparam logic [ANGLE_BITS-1:0] SECT1 = ANGLE_BITS'(((64'd1 << ANGLE_BITS) + 64'd3) / 64'd6);
  localparam logic [ANGLE_BITS-1:0] SECT2 = ANGLE_BITS'(((64'd2 << ANGLE_BITS) + 64'd3) / 64'd6);
  localparam logic [ANGLE_BITS-1:0] SECT3 = ANGLE_BITS'(((64'd3 << ANGLE_BITS) + 64'd3) / 64'd6);
  localparam logic [ANGLE_BITS-1:0] SECT4 = ANGLE_BITS'(((64'd4 << ANGLE_BITS) + 64'd3) / 64'd6);
  localparam logic [ANGLE_BITS-1:0] SECT5 = ANGLE_BITS'(((64'd5 << ANGLE_BITS) + 64'd3) / 64'd6);

  logic [STEP_NUM_W-1:0]  step_num;
  logic [SPEED_W-1:0]     speed_num;
  logic [PHASE_W-1:0]     phase_off;

  logic                   tick_q;
  logic                   zero_q;
  logic [SECTOR_W-1:0]    sector_q;
  logic [PERIOD_BITS-1:0] divisor;
  logic [PERIOD_BITS-1:0] rem_a, rem_b;
  logic [NUM_W-1:0]       quo_a, quo_b;

  logic [ANGLE_BITS-1:0]  angle_acc;
  logic [STEP_W-1:0]      angle_step;
  logic [SPEED_W-1:0]     speed_reg;

  logic                   out_valid;
  logic [OUT_ANGLE_W-1:0] out_angle;
  logic [SPEED_W-1:0]     out_speed;
  hae_status_t            out_status;

  logic [PERIOD_BITS:0]   trial_a, trial_b, div_ext;
  logic                   ge_a, ge_b;
  logic [PERIOD_BITS-1:0] rem_a_next, rem_b_next;

  logic [ANGLE_BITS-1:0]  sector_base;
  logic                   sector_ok;
  logic                   update_div;
  logic [STEP_W-1:0]      step_sat;
  logic [ANGLE_BITS-1:0]  angle_next;
  logic [STEP_W-1:0]      step_next;
  logic [SPEED_W-1:0]     speed_next;
  hae_status_t            status_next;

  // one restoring step per cycle for both quotients
  always_comb begin
    div_ext    = {1'b0, divisor};
    trial_a    = {rem_a, quo_a[NUM_W-1]};
    trial_b    = {rem_b, quo_b[NUM_W-1]};
    ge_a       = (trial_a >= div_ext);
    ge_b       = (trial_b >= div_ext);
    rem_a_next = ge_a ? PERIOD_BITS'(trial_a - div_ext) : trial_a[PERIOD_BITS-1:0];
    rem_b_next = ge_b ? PERIOD_BITS'(trial_b - div_ext) : trial_b[PERIOD_BITS-1:0];
  end

  always_comb begin
    unique case (sector_q)
      3'd1:    sector_base = SECT1;
      3'd2:    sector_base = SECT2;
      3'd3:    sector_base = SECT3;
      3'd4:    sector_base = SECT4;
      3'd5:    sector_base = SECT5;
      default: sector_base = '0;
    endcase
    sector_ok  = (sector_q != SECTOR_NONE);
    update_div = !tick_q && !zero_q;
    step_sat   = (|quo_a[NUM_W-1:STEP_W]) ? '1 : quo_a[STEP_W-1:0];

    if (tick_q) begin
      angle_next = angle_acc + ANGLE_BITS'(angle_step);
    end else if (sector_ok) begin
      angle_next = sector_base + ANGLE_BITS'(phase_off);
    end else begin
      angle_next = angle_acc;
    end

    step_next  = update_div ? step_sat : angle_step;
    speed_next = update_div ? quo_b : speed_reg;

    priority if (tick_q) begin
      status_next = STATUS_OK;
    end else if (zero_q) begin
      status_next = STATUS_ZERO_PERIOD;
    end else if (!sector_ok) begin
      status_next = STATUS_BAD_HALL;
    end else begin
      status_next = STATUS_OK;
    end
  end

  always_comb begin
    stat.in_tick        = in_tuser;
    stat.in_zero_period = (in_tdata[PERIOD_BITS-1:0] == '0);
    stat.out_free       = !out_valid || out_tready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_num  <= STEP_NUM_RESET;
      speed_num <= SPEED_NUM_RESET;
      phase_off <= PHASE_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_STEP_NUM) begin
        step_num <= cfg_wdata[STEP_NUM_W-1:0];
      end
      if (cfg_index == REG_SPEED_NUM) begin
        speed_num <= cfg_wdata[SPEED_W-1:0];
      end
      if (cfg_index == REG_PHASE) begin
        phase_off <= cfg_wdata[PHASE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      tick_q   <= in_tuser;
      zero_q   <= (in_tdata[PERIOD_BITS-1:0] == '0);
      sector_q <= hae_sector(in_tdata[PERIOD_W +: HALL_W]);
    end
    if (cmd.div_start) begin
      divisor <= in_tdata[PERIOD_BITS-1:0];
      rem_a   <= '0;
      rem_b   <= '0;
      quo_a   <= NUM_W'(step_num);
      quo_b   <= NUM_W'(speed_num);
    end else if (cmd.div_step) begin
      rem_a <= rem_a_next;
      rem_b <= rem_b_next;
      quo_a <= {quo_a[NUM_W-2:0], ge_a};
      quo_b <= {quo_b[NUM_W-2:0], ge_b};
    end
    if (cmd.commit) begin
      out_angle  <= OUT_ANGLE_W'(angle_next);
      out_speed  <= speed_next;
      out_status <= status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_acc  <= '0;
      angle_step <= '0;
      speed_reg  <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.commit) begin
        angle_acc  <= angle_next;
        angle_step <= step_next;
        speed_reg  <= speed_next;
        out_valid  <= 1'b1;
      end else if (out_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid;
  assign out_tdata  = OUT_DATA_W'({out_speed, out_angle});
  assign out_tuser  = out_status;

  `HAE_ASSERT(a_commit_free, clk, rst, cmd.commit |-> stat.out_free, "result overwritten")
  `HAE_ASSERT(a_commit_valid, clk, rst, cmd.commit |=> out_valid, "result not presented")
  `HAE_ASSERT(a_angle_hold, clk, rst, !cmd.commit |=> $stable(angle_acc), "angle moved")

endmodule

// File: rtl/hall_angle_estimator_unit.sv
// Hall angle estimator, top level: joins controller and datapath.
// Depends on hae_pkg, hae_ctrl and hae_datapath.
//
// Input stream: tuser = kind (0 hall capture, 1 PWM tick); tdata carries
// capture_period and hall_state. One result per input transaction on the
// output stream: tdata = angle and speed, tuser = status.
// Config port: cfg_we with cfg_index 0 step numerator, 1 speed numerator, 2 phase offset;
// the user must write it only while the block is idle; the block does not enforce this.
// A PWM tick or a zero-period capture goes from acceptance straight to the
// EMIT state; a capture with nonzero period first passes through the DIV
// state, the shared restoring divider (one quotient bit per cycle for step
// and speed together). EMIT loads the output register and raises out_tvalid
// once the register is free. One item is in work at a time; the next is
// accepted the cycle after the result is loaded.
// A stalled receiver holds the result in the output register; the block
// still accepts and works on one further item and then waits.
// Reset (rst, synchronous): config registers return to their defaults,
// angle, step and speed clear to zero, and the output stream goes empty.
module hall_angle_estimator_unit #(
  parameter int ANGLE_BITS  = 16,
  parameter int PERIOD_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [hae_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hae_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [hae_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // capture_period[31:0], hall_state[34:32]
  input  logic                           s_axis_tuser,  // kind
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [hae_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // angle[15:0], speed[41:16]
  output logic [1:0]                     m_axis_tuser   // status
);
  import hae_pkg::*;

  hae_cmd_t  cmd;
  hae_stat_t stat;

  hae_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_tvalid (s_axis_tvalid),
    .in_tready (s_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  hae_datapath #(
    .ANGLE_BITS  (ANGLE_BITS),
    .PERIOD_BITS (PERIOD_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (s_axis_tdata),
    .in_tuser   (s_axis_tuser),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (m_axis_tvalid),
    .out_tready (m_axis_tready),
    .out_tdata  (m_axis_tdata),
    .out_tuser  (m_axis_tuser)
  );

endmodule
